/* sv/dmtq_pkg.sv */
// dmtq_pkg: types and constants for the delayed message timer queue
// holds the transfer structs, the cell link types and the result kind codes
// no dependencies
`timescale 1ns / 1ps

package dmtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam logic [1:0] KIND_RELEASED = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] release_time;
        logic [3:0]  destination;
        logic [7:0]  message_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_destination;
        logic [7:0]  out_tag;
        logic [31:0] current_time;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] time_due;
        logic [3:0]  dest;
        logic [7:0]  tag;
    } t_entry;

    // what every cell sees from its neighbor
    typedef struct packed {
        logic   occ;
        logic   keep;
        t_entry entry;
    } t_link;

    // broadcast control for the whole row
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

/* sv/dmtq_cell.sv */
// dmtq_cell: one slot of the sorted timer chain
// holds one entry and its occupied flag; shifts right on insert, left on pop
// depends on dmtq_pkg
`timescale 1ns / 1ps

module dmtq_cell
    import dmtq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link
);

    logic   r_occ;
    t_entry r_entry;
    logic   n_occ;
    t_entry n_entry;
    logic   w_keep;

    // equal times stay ahead of the new entry
    assign w_keep = r_occ && (r_entry.time_due <= i_ctl.new_entry.time_due);

    always_comb begin
        n_occ   = r_occ;
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (!w_keep) begin
                if (i_left.keep) begin
                    n_occ   = 1'b1;
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_occ   = i_left.occ;
                    n_entry = i_left.entry;
                end
            end
        end else if (i_ctl.pop) begin
            n_occ   = i_right.occ;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.occ   = r_occ;
    assign o_link.keep  = w_keep;
    assign o_link.entry = r_entry;

endmodule

/* sv/delayed_message_timer_queue.sv */
// delayed_message_timer_queue: sorted queue of delayed messages on a row of cells
// top level: tick counter, release sequencer, output register
// depends on dmtq_pkg and dmtq_cell
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-------------------------
//   input   | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//   output  | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
// an insert: transfer in, result in the output register next cycle
// a tick advances the tick counter, then releases the due entries, up to MAX_RESULTS per tick;
// releases pop the head cell, one per cycle, as the output register frees up
// input stalls while a tick is releasing or a result waits in the output register
// synchronous active-low reset empties the row and clears the tick counter
`timescale 1ns / 1ps

module delayed_message_timer_queue
    import dmtq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_REL  = 1'b1;

    logic             r_state;
    logic [31:0]      r_time;
    logic [CNT_W-1:0] r_rel_cnt;
    logic             r_out_valid;
    t_out_item        r_out;

    t_link            w_link [QUEUE_DEPTH];
    t_cell_ctl        w_ctl;
    logic [QUEUE_DEPTH-1:0] w_occ;

    logic w_in_acc;
    logic w_out_free;
    logic w_full;
    logic w_due0;
    logic w_due1;
    logic w_pop;
    logic w_last;

    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = w_link[QUEUE_DEPTH-1].occ;

    assign w_due0 = w_link[0].occ && (w_link[0].entry.time_due <= r_time);
    assign w_due1 = w_link[1].occ && (w_link[1].entry.time_due <= r_time);
    assign w_pop  = (r_state == ST_REL) && w_out_free && w_due0;
    assign w_last = !w_due1 || (r_rel_cnt == CNT_W'(MAX_RESULTS - 1));

    assign w_ctl.insert             = w_in_acc && (i_in_data.action == ACT_INSERT) && !w_full;
    assign w_ctl.pop                = w_pop;
    assign w_ctl.new_entry.time_due = i_in_data.release_time;
    assign w_ctl.new_entry.dest     = i_in_data.destination;
    assign w_ctl.new_entry.tag      = i_in_data.message_tag;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_link w_left;
            t_link w_right;
            if (gi == 0) begin : g_head
                assign w_left = '{occ: 1'b0, keep: 1'b1, entry: '0};
            end else begin : g_mid_l
                assign w_left = w_link[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right = '{occ: 1'b0, keep: 1'b0, entry: '0};
            end else begin : g_mid_r
                assign w_right = w_link[gi+1];
            end
            dmtq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[gi])
            );
            assign w_occ[gi] = w_link[gi].occ;
        end
    endgenerate

    // sequencer and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_time    <= '0;
            r_rel_cnt <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_in_data.action == ACT_TICK)) begin
                        r_time    <= r_time + 32'd1;
                        r_rel_cnt <= '0;
                        r_state   <= ST_REL;
                    end
                end
                ST_REL: begin
                    if (!w_due0) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_rel_cnt <= r_rel_cnt + CNT_W'(1);
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && (i_in_data.action == ACT_INSERT)) begin
            r_out_valid <= 1'b1;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.action == ACT_INSERT)) begin
            r_out.kind            <= w_full ? KIND_REJECTED : KIND_ACCEPTED;
            r_out.out_destination <= '0;
            r_out.out_tag         <= i_in_data.message_tag;
            r_out.current_time    <= r_time;
            r_out.last            <= 1'b1;
        end else if (w_pop) begin
            r_out.kind            <= KIND_RELEASED;
            r_out.out_destination <= w_link[0].entry.dest;
            r_out.out_tag         <= w_link[0].entry.tag;
            r_out.current_time    <= r_time;
            r_out.last            <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // occupied cells always form a prefix of the row
    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ >> 1) & ~w_occ) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> ($countones(w_occ) == $past($countones(w_occ)) + 1))
        else $error("accepted insert did not add exactly one entry");

    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.action == ACT_TICK)) |=> (r_time == $past(r_time) + 32'd1))
        else $error("tick transfer did not advance the counter");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> ($countones(w_occ) + 1 == $past($countones(w_occ))))
        else $error("release did not remove exactly one entry");
`endif

endmodule
